// ===== hdl/cda_pkg.sv =====
// Shared types, codes and calendar helpers for the calendar date adder.
package cda_pkg;

    localparam int DAY_W            = 5;
    localparam int MONTH_W          = 4;
    localparam int YEAR_W           = 14;
    localparam int AMT_FIELD_W      = 16;
    localparam int IN_DATA_W        = 40;
    localparam int OUT_DATA_W       = 24;
    localparam int YEAR_MAX_DEF     = 9999;
    localparam int AMOUNT_WIDTH_DEF = 16;

    localparam logic [DAY_W-1:0]   DAY_RESET   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_RESET = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = 14'd2000;
    localparam logic [MONTH_W-1:0] MONTH_JAN   = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB   = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR   = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN   = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP   = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV   = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC   = 4'd12;

    // 25 * INV25 == 1 mod 2^14; y divisible by 25 iff y * INV25 mod 2^14 <= DIV25_LIM
    localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

    typedef enum logic [1:0] {
        FUNC_LOAD       = 2'd0,
        FUNC_ADD_DAYS   = 2'd1,
        FUNC_ADD_MONTHS = 2'd2,
        FUNC_ADD_YEARS  = 2'd3
    } cda_func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DAYS,
        ST_MON_DIV,
        ST_MON_APPLY,
        ST_YEARS,
        ST_PUBLISH
    } cda_state_t;

    typedef struct packed {
        logic capture;
        logic do_load;
        logic day_step;
        logic mon_div;
        logic mon_apply;
        logic year_add;
        logic publish;
    } cda_cmd_t;

    typedef struct packed {
        logic amt_zero;
        logic out_busy;
    } cda_status_t;

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [2*YEAR_W-1:0] p;
        logic                d25;
        p   = y * INV25;
        d25 = (p[YEAR_W-1:0] <= DIV25_LIM);
        // div by 100 = div by 4 and 25, div by 400 = div by 16 and 25
        return ((y[1:0] == 2'd0) && !d25) || ((y[3:0] == 4'd0) && d25);
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== hdl/cda_ctrl.sv =====
// Sequencing state machine for the calendar date adder.
module cda_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic [1:0]           s_tuser,   // [1:0] func
    output logic                 s_tready,
    input  cda_pkg::cda_status_t status,
    output cda_pkg::cda_cmd_t    cmd
);
    import cda_pkg::*;

    cda_state_t state_reg, state_next;
    logic       accept;

    assign accept = s_tvalid && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cda_func_t'(s_tuser))
                        FUNC_LOAD:       state_next = ST_LOAD;
                        FUNC_ADD_DAYS:   state_next = ST_DAYS;
                        FUNC_ADD_MONTHS: state_next = ST_MON_DIV;
                        FUNC_ADD_YEARS:  state_next = ST_YEARS;
                        default:         state_next = ST_LOAD;
                    endcase
                end
            end
            ST_LOAD:      state_next = ST_PUBLISH;
            ST_DAYS:
            begin
                if (status.amt_zero)
                begin
                    state_next = ST_PUBLISH;
                end
            end
            ST_MON_DIV:   state_next = ST_MON_APPLY;
            ST_MON_APPLY: state_next = ST_PUBLISH;
            ST_YEARS:     state_next = ST_PUBLISH;
            ST_PUBLISH:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE);
        cmd           = '0;
        cmd.capture   = accept;
        case (state_reg)
            ST_LOAD:      cmd.do_load   = 1'b1;
            ST_DAYS:      cmd.day_step  = !status.amt_zero;
            ST_MON_DIV:   cmd.mon_div   = 1'b1;
            ST_MON_APPLY: cmd.mon_apply = 1'b1;
            ST_YEARS:     cmd.year_add  = 1'b1;
            ST_PUBLISH:   cmd.publish   = !status.out_busy;
            default:      cmd.publish   = 1'b0;
        endcase
    end

endmodule

// ===== hdl/cda_datapath.sv =====
// Date registers, month walker, month divider, year adder and output register.
module cda_datapath
#(
    parameter int YEAR_MAX     = cda_pkg::YEAR_MAX_DEF,
    parameter int AMOUNT_WIDTH = cda_pkg::AMOUNT_WIDTH_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  cda_pkg::cda_cmd_t                cmd,
    output cda_pkg::cda_status_t             status,
    // amount[15:0], load_day[20:16], load_month[24:21], load_year[38:25], zero pad
    input  logic [cda_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cur_day[4:0], cur_month[8:5], cur_year[22:9], year_overflow[23]
    output logic [cda_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import cda_pkg::*;

    localparam int AW  = AMOUNT_WIDTH;
    localparam int NMW = AW + 1;                       // month index + amount
    localparam int RK  = NMW + 4;                      // reciprocal shift
    localparam int PW  = NMW + RK;
    localparam int SW  = ((NMW > YEAR_W) ? NMW : YEAR_W) + 1;
    localparam int CW  = (AW > DAY_W) ? AW : DAY_W;
    localparam logic [RK-1:0]     RECIP12 = RK'(((64'd1 << RK) + 64'd11) / 64'd12);
    localparam logic [YEAR_W-1:0] YMAX    = YEAR_W'(YEAR_MAX);

    // date state
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic               leap_reg;
    logic               ovf_reg,   ovf_next;

    // captured transaction payload and work registers
    logic [AW-1:0]      amt_reg,   amt_next;
    logic [DAY_W-1:0]   ld_day_reg;
    logic [MONTH_W-1:0] ld_month_reg;
    logic [YEAR_W-1:0]  ld_year_reg;
    logic [NMW-1:0]     nm_reg;
    logic [NMW-1:0]     q_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic [AW-1:0]      amt_in;
    logic [NMW-1:0]     nm_calc;
    logic [PW-1:0]      prod;
    logic [NMW-1:0]     rem;
    logic [NMW-1:0]     addend;
    logic [SW-1:0]      year_sum;
    logic [YEAR_W-1:0]  year_sat;
    logic               year_ovf;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   to_next;
    logic [CW-1:0]      amt_ext;
    logic [CW-1:0]      to_ext;
    logic [CW-1:0]      amt_left;
    logic               carry_month;

    generate
        if (AW >= AMT_FIELD_W)
        begin : g_amt_wide
            assign amt_in = AW'(s_tdata[AMT_FIELD_W-1:0]);
        end
        else
        begin : g_amt_narrow
            assign amt_in = s_tdata[AW-1:0];
        end
    endgenerate

    // months: nm / 12 by reciprocal multiply, remainder on the next cycle
    assign nm_calc = NMW'(amt_reg) + NMW'(month_reg - MONTH_JAN);
    assign prod    = PW'(nm_calc) * PW'(RECIP12);
    assign rem     = nm_reg - ((q_reg << 3) + (q_reg << 2));

    // shared saturating year adder
    always_comb
    begin
        if (cmd.year_add)
        begin
            addend = NMW'(amt_reg);
        end
        else if (cmd.mon_apply)
        begin
            addend = q_reg;
        end
        else
        begin
            addend = NMW'(1);
        end
        year_sum = SW'(year_reg) + SW'(addend);
        year_ovf = (year_sum > SW'(YEAR_MAX));
        year_sat = year_ovf ? YMAX : year_sum[YEAR_W-1:0];
    end

    // one month per step; a day past the month end counts as its last day
    assign len         = month_length(month_reg, leap_reg);
    assign to_next     = (day_reg <= len) ? (len - day_reg + 5'd1) : 5'd1;
    assign amt_ext     = CW'(amt_reg);
    assign to_ext      = CW'(to_next);
    assign carry_month = (amt_ext >= to_ext);
    assign amt_left    = amt_ext - to_ext;

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        ovf_next   = ovf_reg;
        amt_next   = amt_reg;
        if (cmd.capture)
        begin
            ovf_next = 1'b0;
            amt_next = amt_in;
        end
        else if (cmd.do_load)
        begin
            day_next = (ld_day_reg == '0) ? DAY_RESET : ld_day_reg;
            if (ld_month_reg == '0)
            begin
                month_next = MONTH_JAN;
            end
            else if (ld_month_reg > MONTH_DEC)
            begin
                month_next = MONTH_DEC;
            end
            else
            begin
                month_next = ld_month_reg;
            end
            if (ld_year_reg == '0)
            begin
                year_next = YEAR_W'(1);
            end
            else if (ld_year_reg > YMAX)
            begin
                year_next = YMAX;
                ovf_next  = 1'b1;
            end
            else
            begin
                year_next = ld_year_reg;
            end
        end
        else if (cmd.day_step)
        begin
            if (carry_month)
            begin
                amt_next = amt_left[AW-1:0];
                day_next = DAY_RESET;
                if (month_reg >= MONTH_DEC)
                begin
                    month_next = MONTH_JAN;
                    year_next  = year_sat;
                    ovf_next   = ovf_reg | year_ovf;
                end
                else
                begin
                    month_next = month_reg + MONTH_W'(1);
                end
            end
            else
            begin
                day_next = day_reg + amt_ext[DAY_W-1:0];
                amt_next = '0;
            end
        end
        else if (cmd.mon_apply)
        begin
            month_next = rem[MONTH_W-1:0] + MONTH_W'(1);
            year_next  = year_sat;
            ovf_next   = ovf_reg | year_ovf;
        end
        else if (cmd.year_add)
        begin
            year_next = year_sat;
            ovf_next  = ovf_reg | year_ovf;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            day_reg       <= DAY_RESET;
            month_reg     <= MONTH_RESET;
            year_reg      <= YEAR_RESET;
            leap_reg      <= is_leap(YEAR_RESET);
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            day_reg       <= day_next;
            month_reg     <= month_next;
            year_reg      <= year_next;
            // follows year_reg in the next cycle; February is never walked right after a year change
            leap_reg      <= is_leap(year_reg);
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amt_reg <= amt_next;
        if (cmd.capture)
        begin
            ld_day_reg   <= s_tdata[20:16];
            ld_month_reg <= s_tdata[24:21];
            ld_year_reg  <= s_tdata[38:25];
        end
        if (cmd.mon_div)
        begin
            nm_reg <= nm_calc;
            q_reg  <= prod[PW-1:RK];
        end
        if (cmd.publish)
        begin
            out_data_reg <= {ovf_reg, year_reg, month_reg, day_reg};
        end
    end

    assign status.amt_zero = (amt_reg == '0);
    assign status.out_busy = out_valid_reg && !m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

`ifndef SYNTHESIS
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (month_reg >= MONTH_JAN) && (month_reg <= MONTH_DEC))
        else $error("month register out of range");

    a_day_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (day_reg != '0) && (year_reg != '0))
        else $error("day or year register is zero");

    a_walk_progress: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.day_step |=> (amt_reg < $past(amt_reg)))
        else $error("day walk did not consume any days");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.publish && ovf_reg) |=> (m_tdata[22:9] == YMAX))
        else $error("overflow reported without a saturated year");
`endif

endmodule

// ===== hdl/calendar_date_adder.sv =====
// Top level of the Gregorian calendar date adder.
// Holds one date (reset: 1 January 2000) and takes one transaction at a time: tuser selects
// load, add days, add months or add years, and every transaction returns one result with
// the new date and a flag set when the year saturated at YEAR_MAX. A load passes through the
// load and publish states; adding months through month divide, month apply and publish;
// adding years through the year and publish states. Adding days walks the calendar one month
// per cycle in the day stepper, then publishes. The result sits in an output register; a
// new transaction is taken once that register has been loaded, even while it still waits.
module calendar_date_adder
#(
    parameter int YEAR_MAX     = cda_pkg::YEAR_MAX_DEF,
    parameter int AMOUNT_WIDTH = cda_pkg::AMOUNT_WIDTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // amount[15:0], load_day[20:16], load_month[24:21], load_year[38:25], zero pad
    input  logic [cda_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cur_day[4:0], cur_month[8:5], cur_year[22:9], year_overflow[23]
    output logic [cda_pkg::OUT_DATA_W-1:0] m_tdata
);
    import cda_pkg::*;

    cda_cmd_t    cmd;
    cda_status_t status;

    cda_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cda_datapath
    #(
        .YEAR_MAX     (YEAR_MAX),
        .AMOUNT_WIDTH (AMOUNT_WIDTH)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== tb/tb_calendar_date_adder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the calendar date adder: directed table, then random date operations.
module tb_calendar_date_adder;
    import cda_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int YEAR_LIMIT   = YEAR_MAX_DEF;
    localparam int RANDOM_ITEMS = 250;
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 20000;
    localparam int TAIL_CYCLES  = 20;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               ovf;
    } date_t;

    typedef struct packed {
        cda_func_t              func;
        logic [AMT_FIELD_W-1:0] amount;
        logic [DAY_W-1:0]       day;
        logic [MONTH_W-1:0]     month;
        logic [YEAR_W-1:0]      year;
        logic                   typed;
        date_t                  want;
    } date_op_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]            s_tuser  = FUNC_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    // predicted calendar state, reset value 1 January 2000
    int unsigned cal_day   = 1;
    int unsigned cal_month = 1;
    int unsigned cal_year  = 2000;

    date_t    expected_dates[$];
    date_op_t directed_ops[$];
    int       fail_count    = 0;
    int       burst_left    = 0;
    int       idle_cycles   = 0;
    bit       hold_request  = 1'b0;

    calendar_date_adder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == 2)
            return is_leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        return 31;
    endfunction

    function automatic bit year_carry(input int unsigned n);
        if (cal_year + n > YEAR_LIMIT)
        begin
            cal_year = YEAR_LIMIT;
            return 1'b1;
        end
        cal_year = cal_year + n;
        return 1'b0;
    endfunction

    function automatic date_t advance_calendar(input date_op_t op);
        int unsigned n;
        int unsigned len;
        int unsigned to_next;
        int unsigned nm;
        date_t       res;
        res.ovf = 1'b0;
        n = op.amount;
        case (op.func)
            FUNC_LOAD:
            begin
                cal_day   = (op.day == 0) ? 1 : op.day;
                cal_month = (op.month == 0) ? 1 : (op.month > 12) ? 12 : op.month;
                cal_year  = (op.year == 0) ? 1 : op.year;
                if (cal_year > YEAR_LIMIT)
                begin
                    cal_year = YEAR_LIMIT;
                    res.ovf  = 1'b1;
                end
            end
            FUNC_ADD_DAYS:
            begin
                // a day past the month end counts as its last day
                while (n > 0)
                begin
                    len     = days_in_month(cal_month, cal_year);
                    to_next = (cal_day <= len) ? len - cal_day + 1 : 1;
                    if (n >= to_next)
                    begin
                        n       = n - to_next;
                        cal_day = 1;
                        if (cal_month >= 12)
                        begin
                            cal_month = 1;
                            if (year_carry(1))
                                res.ovf = 1'b1;
                        end
                        else
                            cal_month = cal_month + 1;
                    end
                    else
                    begin
                        cal_day = cal_day + n;
                        n       = 0;
                    end
                end
            end
            FUNC_ADD_MONTHS:
            begin
                nm        = cal_month - 1 + n;
                cal_month = nm % 12 + 1;
                if (year_carry(nm / 12))
                    res.ovf = 1'b1;
            end
            default:
            begin
                if (year_carry(n))
                    res.ovf = 1'b1;
            end
        endcase
        res.day   = DAY_W'(cal_day);
        res.month = MONTH_W'(cal_month);
        res.year  = YEAR_W'(cal_year);
        return res;
    endfunction

    task automatic add_row(input cda_func_t f, input int unsigned amt, input int unsigned d,
                           input int unsigned m, input int unsigned y, input bit typed,
                           input int unsigned wd, input int unsigned wm, input int unsigned wy,
                           input bit wo);
        date_op_t op;
        op.func       = f;
        op.amount     = AMT_FIELD_W'(amt);
        op.day        = DAY_W'(d);
        op.month      = MONTH_W'(m);
        op.year       = YEAR_W'(y);
        op.typed      = typed;
        op.want.day   = DAY_W'(wd);
        op.want.month = MONTH_W'(wm);
        op.want.year  = YEAR_W'(wy);
        op.want.ovf   = wo;
        directed_ops.push_back(op);
    endtask

    // offer one transaction, bursts of back-to-back items with random gaps between them
    task automatic send_op(input date_op_t op);
        int gap;
        date_t pred;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, op.year, op.month, op.day, op.amount};
        s_tuser  <= op.func;
        do @(posedge clk); while (!s_tready);
        pred = advance_calendar(op);
        expected_dates.push_back(op.typed ? op.want : pred);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (expected_dates.size() != 0);
    endtask

    task automatic random_op();
        date_op_t    op;
        int unsigned sel;
        int unsigned sz;
        op       = '0;
        sel      = $urandom_range(0, 99);
        sz       = $urandom_range(0, 19);
        op.amount = AMT_FIELD_W'($urandom);
        if (sel < 25)
        begin
            op.func = FUNC_LOAD;
            if ($urandom_range(0, 3) == 0)
            begin
                // raw field bits: zero, oversize days, months and years
                op.day   = DAY_W'($urandom);
                op.month = MONTH_W'($urandom);
                op.year  = YEAR_W'($urandom);
            end
            else
            begin
                op.day   = DAY_W'($urandom_range(1, 31));
                op.month = MONTH_W'($urandom_range(1, 12));
                if (sz < 10)
                    op.year = YEAR_W'($urandom_range(1, 2500));
                else if (sz < 16)
                    op.year = YEAR_W'($urandom_range(YEAR_LIMIT - 99, YEAR_LIMIT));
                else
                    op.year = YEAR_W'($urandom_range(1, YEAR_LIMIT));
            end
        end
        else if (sel < 60)
        begin
            op.func = FUNC_ADD_DAYS;
            if (sz < 12)
                op.amount = AMT_FIELD_W'($urandom_range(0, 400));
            else if (sz < 17)
                op.amount = AMT_FIELD_W'($urandom_range(0, 5000));
        end
        else if (sel < 80)
        begin
            op.func = FUNC_ADD_MONTHS;
            if (sz < 14)
                op.amount = AMT_FIELD_W'($urandom_range(0, 40));
            else if (sz < 18)
                op.amount = AMT_FIELD_W'($urandom_range(0, 2000));
        end
        else
        begin
            op.func = FUNC_ADD_YEARS;
            if (sz < 14)
                op.amount = AMT_FIELD_W'($urandom_range(0, 50));
            else if (sz < 18)
                op.amount = AMT_FIELD_W'($urandom_range(0, YEAR_LIMIT));
        end
        send_op(op);
    endtask

    initial
    begin : stimulus
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        add_row(FUNC_ADD_DAYS,   0,     5,  5,  5,     1'b1, 1,  1,  2000, 1'b0);
        add_row(FUNC_LOAD,       0,     31, 12, 9999,  1'b1, 31, 12, 9999, 1'b0);
        add_row(FUNC_ADD_DAYS,   1,     0,  0,  0,     1'b1, 1,  1,  9999, 1'b1);
        add_row(FUNC_LOAD,       0,     0,  0,  0,     1'b1, 1,  1,  1,    1'b0);
        add_row(FUNC_LOAD,       0,     31, 15, 16383, 1'b1, 31, 12, 9999, 1'b1);
        add_row(FUNC_LOAD,       65535, 10, 10, 2010,  1'b1, 10, 10, 2010, 1'b0);
        add_row(FUNC_LOAD,       0,     29, 2,  2000,  1'b1, 29, 2,  2000, 1'b0);
        // Feb 29 carried into a common year, then one day past the month end
        add_row(FUNC_ADD_YEARS,  1,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_DAYS,   1,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_LOAD,       0,     28, 2,  1900,  1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_DAYS,   1,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_LOAD,       0,     28, 2,  2024,  1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_DAYS,   1,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_MONTHS, 0,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_MONTHS, 65535, 0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_LOAD,       0,     1,  1,  1,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_YEARS,  65535, 0,  0,  0,     1'b1, 1,  1,  9999, 1'b1);
        add_row(FUNC_LOAD,       0,     15, 6,  2020,  1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_DAYS,   65535, 0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_MONTHS, 11,    0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_MONTHS, 12,    0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_LOAD,       0,     31, 1,  2023,  1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_MONTHS, 1,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_DAYS,   1,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);
        add_row(FUNC_ADD_YEARS,  0,     0,  0,  0,     1'b0, 0,  0,  0,    1'b0);

        for (i = 0; i < directed_ops.size(); i++)
            send_op(directed_ops[i]);
        drain_results();

        // long receiver hold while the sender keeps pushing short transactions
        hold_request = 1'b1;
        burst_left   = 30;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            random_op();
            if (i % 80 == 79)
                drain_results();
        end
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_dates.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver: changes its stall pattern whenever its mode counter wraps
    initial
    begin : receiver
        int mode;
        int mode_cycles;
        mode        = 0;
        mode_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode_cycles = mode_cycles + 1;
                if (mode_cycles == 64)
                begin
                    mode_cycles = 0;
                    mode        = $urandom_range(0, 3);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (mode_cycles % 4 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        date_t want;
        date_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.day   = m_tdata[4:0];
            got.month = m_tdata[8:5];
            got.year  = m_tdata[22:9];
            got.ovf   = m_tdata[23];
            if (expected_dates.size() == 0)
            begin
                $display("%0t: unexpected result %0d/%0d/%0d ovf %0b", $time,
                         got.day, got.month, got.year, got.ovf);
                fail_count = fail_count + 1;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year || got.ovf !== want.ovf)
                begin
                    $display("%0t: expected %0d/%0d/%0d ovf %0b, actual %0d/%0d/%0d ovf %0b",
                             $time, want.day, want.month, want.year, want.ovf,
                             got.day, got.month, got.year, got.ovf);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // watchdog: cycles without any transaction on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hdl/cda_pkg.sv
hdl/cda_ctrl.sv
hdl/cda_datapath.sv
hdl/calendar_date_adder.sv
tb/tb_calendar_date_adder.sv
